### hw/rtl/offp_pkg.sv
// Package for the optical flow frame parser: parser phases, frame bytes,
// function codes, report kinds and store geometry. No dependencies.
`default_nettype none

package offp_pkg;

   localparam logic [7:0] HDR_BYTE    = 8'hAA;
   localparam logic [7:0] FUNC_LIMIT  = 8'hF1;
   localparam int         MAX_PAYLOAD = 44;
   localparam int         STORE_DEPTH = 17;
   localparam int         IDX_W       = 6;

   localparam logic [7:0] FUNC_FLOW   = 8'h51;
   localparam logic [7:0] FUNC_HEIGHT = 8'h52;
   localparam logic [7:0] FUNC_IMU    = 8'h53;
   localparam logic [7:0] FUNC_ATT    = 8'h54;

   // store positions
   localparam int POS_FUNC  = 2;
   localparam int POS_LEN   = 3;
   localparam int POS_MODE  = 4;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_HDR2  = 3'd1,
      PH_FUNC  = 3'd2,
      PH_LEN   = 3'd3,
      PH_PAY   = 3'd4,
      PH_CKSUM = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      KIND_FLOW_RAW   = 3'd0,
      KIND_FLOW_FUSED = 3'd1,
      KIND_HGT_RAW    = 3'd2,
      KIND_HGT_FUSED  = 3'd3,
      KIND_IMU_RAW    = 3'd4,
      KIND_IMU_FILT   = 3'd5,
      KIND_EULER      = 3'd6,
      KIND_QUAT       = 3'd7
   } kind_type;

endpackage

`default_nettype wire

### hw/rtl/optical_flow_frame_parser_top.sv
// Optical flow frame parser: byte-wise frame sync, checksum, frame decode.
// Depends on offp_pkg.
//
//   channel   dir   handshake              payload
//   req_      in    req_valid/req_ready    req_rx_byte[7:0]
//   rsp_      out   rsp_valid/rsp_ready    rsp_frame_kind, quality, light, word_a..f
//
// One byte per cycle. The checksum byte updates the store and, if the sum
// matches, sets a pending flag; the pending frame is decoded from the store into
// the result register once that register is free. Input stalls only while a decoded
// report waits in the result register and another is pending behind it.
// Synchronous reset returns to idle and zeroes the 17-byte frame store.
`default_nettype none

module optical_flow_frame_parser_top
   import offp_pkg::*;
#(
   parameter int MAX_LEN = MAX_PAYLOAD
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_frame_kind,
   output logic [7:0]       rsp_quality,
   output logic [7:0]       rsp_light,
   output logic [15:0]      rsp_word_a,
   output logic [15:0]      rsp_word_b,
   output logic [15:0]      rsp_word_c,
   output logic [15:0]      rsp_word_d,
   output logic [15:0]      rsp_word_e,
   output logic [15:0]      rsp_word_f
);

   phase_type         phase_ff, phase_in;
   logic [IDX_W-1:0]  bytes_left_ff, bytes_left_in;
   logic [IDX_W-1:0]  payload_count_ff, payload_count_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        store_ff [STORE_DEPTH];
   logic              pend_ff, pend_in;

   logic              rx_take;
   logic              out_free;
   logic              chk_hit;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;

   logic              dec_ok;
   kind_type          dec_kind;
   logic [7:0]        dec_quality, dec_light;
   logic [15:0]       dec_w [6];
   logic              out_load;

   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          kind_ff;
   logic [7:0]        quality_ff, light_ff;
   logic [15:0]       word_ff [6];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !pend_ff || out_free;
   assign rx_take   = req_valid && req_ready;

   // ---------------- frame sync ----------------
   always_comb begin
      phase_in         = phase_ff;
      bytes_left_in    = bytes_left_ff;
      payload_count_in = payload_count_ff;
      sum_in           = sum_ff;
      wr_en            = 1'b0;
      wr_idx           = '0;
      chk_hit          = 1'b0;
      if (rx_take) begin
         case (phase_ff)
            PH_IDLE: begin
               if (req_rx_byte == HDR_BYTE) begin
                  wr_en    = 1'b1;
                  wr_idx   = IDX_W'(0);
                  sum_in   = req_rx_byte;
                  phase_in = PH_HDR2;
               end
            end
            PH_HDR2: begin
               if (req_rx_byte == HDR_BYTE) begin
                  wr_en    = 1'b1;
                  wr_idx   = IDX_W'(1);
                  sum_in   = sum_ff + req_rx_byte;
                  phase_in = PH_FUNC;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_FUNC: begin
               if (req_rx_byte < FUNC_LIMIT) begin
                  wr_en    = 1'b1;
                  wr_idx   = IDX_W'(POS_FUNC);
                  sum_in   = sum_ff + req_rx_byte;
                  phase_in = PH_LEN;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_LEN: begin
               if (req_rx_byte <= 8'(MAX_LEN)) begin
                  wr_en            = 1'b1;
                  wr_idx           = IDX_W'(POS_LEN);
                  sum_in           = sum_ff + req_rx_byte;
                  bytes_left_in    = req_rx_byte[IDX_W-1:0];
                  payload_count_in = '0;
                  phase_in         = PH_PAY;
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_PAY: begin
               // zero length lands here with nothing left: frame dropped
               if (bytes_left_ff != '0) begin
                  wr_en            = 1'b1;
                  wr_idx           = IDX_W'(POS_MODE) + payload_count_ff;
                  sum_in           = sum_ff + req_rx_byte;
                  bytes_left_in    = bytes_left_ff - IDX_W'(1);
                  payload_count_in = payload_count_ff + IDX_W'(1);
                  if (bytes_left_ff == IDX_W'(1)) begin
                     phase_in = PH_CKSUM;
                  end
               end else begin
                  phase_in = PH_IDLE;
               end
            end
            PH_CKSUM: begin
               // checksum byte lands in the store as well when its position lies inside the store
               wr_en    = 1'b1;
               wr_idx   = IDX_W'(POS_MODE) + payload_count_ff;
               chk_hit  = (sum_ff == req_rx_byte);
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      if (rx_take) begin
         pend_in = chk_hit;
      end else begin
         pend_in = pend_ff && !out_free;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         bytes_left_ff    <= '0;
         payload_count_ff <= '0;
         sum_ff           <= '0;
         pend_ff          <= 1'b0;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         phase_ff         <= phase_in;
         bytes_left_ff    <= bytes_left_in;
         payload_count_ff <= payload_count_in;
         sum_ff           <= sum_in;
         pend_ff          <= pend_in;
         for (int i = 0; i < STORE_DEPTH; i++) begin
            if (wr_en && wr_idx == IDX_W'(i)) begin
               store_ff[i] <= req_rx_byte;
            end
         end
      end
   end

   // ---------------- decode ----------------
   // store byte 0 is the only one that can be written while a decode is pending
   always_comb begin
      dec_ok      = 1'b1;
      dec_kind    = KIND_FLOW_RAW;
      dec_quality = '0;
      dec_light   = '0;
      for (int k = 0; k < 6; k++) begin
         dec_w[k] = '0;
      end
      case (store_ff[POS_FUNC])
         FUNC_FLOW: begin
            dec_quality = store_ff[5];
            if (!store_ff[POS_MODE][0]) begin
               dec_kind  = KIND_FLOW_RAW;
               dec_w[0]  = {{8{store_ff[6][7]}}, store_ff[6]};
               dec_w[1]  = {{8{store_ff[7][7]}}, store_ff[7]};
               dec_light = store_ff[8];
            end else begin
               dec_kind  = KIND_FLOW_FUSED;
               dec_w[0]  = {store_ff[6], store_ff[7]};
               dec_w[1]  = {store_ff[8], store_ff[9]};
               dec_w[2]  = {store_ff[10], store_ff[11]};
               dec_w[3]  = {store_ff[12], store_ff[13]};
               dec_light = store_ff[14];
            end
         end
         FUNC_HEIGHT: begin
            dec_kind = store_ff[POS_MODE][0] ? KIND_HGT_FUSED : KIND_HGT_RAW;
            dec_w[0] = {store_ff[5], store_ff[6]};
         end
         FUNC_IMU: begin
            dec_kind = store_ff[POS_MODE][0] ? KIND_IMU_FILT : KIND_IMU_RAW;
            for (int k = 0; k < 6; k++) begin
               dec_w[k] = {store_ff[5 + 2 * k], store_ff[6 + 2 * k]};
            end
         end
         FUNC_ATT: begin
            dec_kind = store_ff[POS_MODE][0] ? KIND_QUAT : KIND_EULER;
            for (int k = 0; k < 3; k++) begin
               dec_w[k] = {store_ff[5 + 2 * k], store_ff[6 + 2 * k]};
            end
            if (store_ff[POS_MODE][0]) begin
               dec_w[3] = {store_ff[11], store_ff[12]};
            end
         end
         default: begin
            dec_ok = 1'b0;
         end
      endcase
      if (store_ff[POS_MODE] > 8'd1) begin
         dec_ok = 1'b0;
      end
   end

   assign out_load     = pend_ff && dec_ok && out_free;
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         kind_ff    <= dec_kind;
         quality_ff <= dec_quality;
         light_ff   <= dec_light;
         for (int k = 0; k < 6; k++) begin
            word_ff[k] <= dec_w[k];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_kind = kind_ff;
   assign rsp_quality    = quality_ff;
   assign rsp_light      = light_ff;
   assign rsp_word_a     = word_ff[0];
   assign rsp_word_b     = word_ff[1];
   assign rsp_word_c     = word_ff[2];
   assign rsp_word_d     = word_ff[3];
   assign rsp_word_e     = word_ff[4];
   assign rsp_word_f     = word_ff[5];

   // ---------------- assertions ----------------
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (pend_ff && rsp_valid_ff))
      else $error("input stalled without a waiting report");

   a_cksum_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rx_take && phase_ff == PH_CKSUM) |=> (phase_ff == PH_IDLE))
      else $error("parser did not return to idle after checksum byte");

   a_payload_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY) |->
         ({1'b0, payload_count_ff} + {1'b0, bytes_left_ff} <= (IDX_W + 1)'(MAX_LEN)))
      else $error("payload count beyond frame length limit");

   a_pend_kept: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && !out_free) |=> pend_ff)
      else $error("pending frame lost while result register full");

endmodule

`default_nettype wire

### tb/sv/optical_flow_frame_parser_top_tb.sv
// Self-checking bench for optical_flow_frame_parser_top: feeds a byte stream of
// directed and random frames, predicts every report, checks them in order.
// Depends on offp_pkg and the parser RTL only.
module optical_flow_frame_parser_top_tb;
   import offp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 10;
   localparam int STREAM_TARGET  = 950;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 20;
   localparam int MAX_SHOWN      = 10;
   localparam int DIR_ROWS       = 21;

   localparam logic [7:0] MODE_RAW     = 8'h00;
   localparam logic [7:0] MODE_FUSED   = 8'h01;
   localparam logic [7:0] MODE_BAD     = 8'hFF;
   localparam logic [7:0] FUNC_UNKNOWN = 8'h50;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  quality;
      logic [7:0]  light;
      logic [15:0] word_a;
      logic [15:0] word_b;
      logic [15:0] word_c;
      logic [15:0] word_d;
      logic [15:0] word_e;
      logic [15:0] word_f;
   } report_type;

   localparam report_type NO_REPORT_VAL = '0;

   // where the expectation for a checksum byte comes from
   typedef enum logic [1:0] {
      FROM_PARSER  = 2'd0,
      NO_REPORT    = 2'd1,
      GIVEN_REPORT = 2'd2
   } exp_src_type;

   typedef struct packed {
      logic [7:0]  b;
      exp_src_type src;
      report_type  rpt;
   } rx_item_type;

   // one frame of stimulus: optional junk bytes, then AA AA func len body cksum
   typedef struct packed {
      logic [3:0]   npre;
      logic [63:0]  pre;
      logic [7:0]   func;
      logic [7:0]   len;
      logic [7:0]   mode;
      logic [127:0] pay;
      logic         rnd;
      logic [7:0]   cks_adj;
      exp_src_type  src;
      report_type   rpt;
   } frame_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_frame_kind;
   logic [7:0]  rsp_quality;
   logic [7:0]  rsp_light;
   logic [15:0] rsp_word_a;
   logic [15:0] rsp_word_b;
   logic [15:0] rsp_word_c;
   logic [15:0] rsp_word_d;
   logic [15:0] rsp_word_e;
   logic [15:0] rsp_word_f;

   optical_flow_frame_parser_top #(
      .MAX_LEN        (MAX_PAYLOAD)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_quality    (rsp_quality),
      .rsp_light      (rsp_light),
      .rsp_word_a     (rsp_word_a),
      .rsp_word_b     (rsp_word_b),
      .rsp_word_c     (rsp_word_c),
      .rsp_word_d     (rsp_word_d),
      .rsp_word_e     (rsp_word_e),
      .rsp_word_f     (rsp_word_f)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   rx_item_type   rx_stream [$];
   report_type    pending_reports [$];
   frame_row_type dir_tab [DIR_ROWS];

   int feed_idx = 0;
   int frames_built = 0;
   int reports_checked = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   int burst_left = 0;
   int gap_left = 0;
   int pat_age = 0;
   int pat_pos = 0;
   logic [15:0] ready_pat = 16'hFFFF;
   logic [7:0]  kinds_seen = '0;

   // parser shadow state
   phase_type   ps_phase;
   logic [5:0]  ps_left;
   logic [5:0]  ps_count;
   logic [7:0]  ps_sum;
   logic [7:0]  ps_store [STORE_DEPTH];

   task automatic store_put(input int idx, input logic [7:0] v);
      if (idx < STORE_DEPTH) ps_store[idx] = v;
   endtask

   function automatic logic [15:0] store_word(input int i);
      return {ps_store[i], ps_store[i + 1]};
   endfunction

   task automatic parse_byte(input logic [7:0] b, output logic hit, output report_type r);
      logic [7:0] fn;
      logic [7:0] md;
      hit = 1'b0;
      r = NO_REPORT_VAL;
      if (ps_phase == PH_IDLE && b == HDR_BYTE) begin
         store_put(0, b);
         ps_sum = b;
         ps_phase = PH_HDR2;
      end else if (ps_phase == PH_HDR2 && b == HDR_BYTE) begin
         store_put(1, b);
         ps_sum += b;
         ps_phase = PH_FUNC;
      end else if (ps_phase == PH_FUNC && b < FUNC_LIMIT) begin
         store_put(POS_FUNC, b);
         ps_sum += b;
         ps_phase = PH_LEN;
      end else if (ps_phase == PH_LEN && b <= MAX_PAYLOAD) begin
         store_put(POS_LEN, b);
         ps_sum += b;
         ps_left = b[5:0];
         ps_count = '0;
         ps_phase = PH_PAY;
      end else if (ps_phase == PH_PAY && ps_left != 0) begin
         ps_left -= 6'd1;
         store_put(POS_MODE + ps_count, b);
         ps_count += 6'd1;
         ps_sum += b;
         if (ps_left == 0) ps_phase = PH_CKSUM;
      end else if (ps_phase == PH_CKSUM) begin
         ps_phase = PH_IDLE;
         // checksum byte lands in the store (when its position lies inside it) before the decode reads it
         store_put(POS_MODE + ps_count, b);
         if (ps_sum == b) begin
            fn = ps_store[POS_FUNC];
            md = ps_store[POS_MODE];
            if (md <= 1) begin
               hit = 1'b1;
               case (fn)
                  FUNC_FLOW: begin
                     r.quality = ps_store[5];
                     if (md[0]) begin
                        r.kind = KIND_FLOW_FUSED;
                        r.word_a = store_word(6);
                        r.word_b = store_word(8);
                        r.word_c = store_word(10);
                        r.word_d = store_word(12);
                        r.light = ps_store[14];
                     end else begin
                        r.kind = KIND_FLOW_RAW;
                        r.word_a = {{8{ps_store[6][7]}}, ps_store[6]};
                        r.word_b = {{8{ps_store[7][7]}}, ps_store[7]};
                        r.light = ps_store[8];
                     end
                  end
                  FUNC_HEIGHT: begin
                     r.kind = md[0] ? KIND_HGT_FUSED : KIND_HGT_RAW;
                     r.word_a = store_word(5);
                  end
                  FUNC_IMU: begin
                     r.kind = md[0] ? KIND_IMU_FILT : KIND_IMU_RAW;
                     r.word_a = store_word(5);
                     r.word_b = store_word(7);
                     r.word_c = store_word(9);
                     r.word_d = store_word(11);
                     r.word_e = store_word(13);
                     r.word_f = store_word(15);
                  end
                  FUNC_ATT: begin
                     r.kind = md[0] ? KIND_QUAT : KIND_EULER;
                     r.word_a = store_word(5);
                     r.word_b = store_word(7);
                     r.word_c = store_word(9);
                     if (md[0]) r.word_d = store_word(11);
                  end
                  default: begin
                     hit = 1'b0;
                  end
               endcase
            end
         end
      end else begin
         ps_phase = PH_IDLE;
      end
   endtask

   task automatic queue_frame(input frame_row_type row);
      logic [7:0] sum;
      logic [7:0] bv;
      sum = 8'h00;
      for (int k = 0; k < row.npre; k++)
         rx_stream.push_back(rx_item_type'{row.pre[63 - 8 * k -: 8], FROM_PARSER,
                                           NO_REPORT_VAL});
      for (int j = -4; j < int'(row.len); j++) begin
         if (j < -2) bv = HDR_BYTE;
         else if (j == -2) bv = row.func;
         else if (j == -1) bv = row.len;
         else if (j == 0) bv = row.mode;
         else if (row.rnd) bv = 8'($urandom_range(0, 255));
         else if (j <= 16) bv = row.pay[127 - 8 * (j - 1) -: 8];
         else bv = 8'h00;
         sum += bv;
         rx_stream.push_back(rx_item_type'{bv, FROM_PARSER, NO_REPORT_VAL});
      end
      rx_stream.push_back(rx_item_type'{8'(sum + row.cks_adj), row.src, row.rpt});
      frames_built++;
   endtask

   function automatic string report_str(input report_type r);
      return $sformatf("kind %0d q %02h l %02h a %04h b %04h c %04h d %04h e %04h f %04h",
                       r.kind, r.quality, r.light, r.word_a, r.word_b, r.word_c,
                       r.word_d, r.word_e, r.word_f);
   endfunction

   task automatic check_report(input report_type got);
      report_type want;
      if (pending_reports.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_SHOWN) $display("unexpected report: %s", report_str(got));
      end else begin
         want = pending_reports.pop_front();
         reports_checked++;
         if (got.kind !== want.kind || got.quality !== want.quality ||
             got.light !== want.light || got.word_a !== want.word_a ||
             got.word_b !== want.word_b || got.word_c !== want.word_c ||
             got.word_d !== want.word_d || got.word_e !== want.word_e ||
             got.word_f !== want.word_f) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
               $display("report %0d mismatch", reports_checked);
               $display("  expected %s", report_str(want));
               $display("  actual   %s", report_str(got));
            end
         end else begin
            kinds_seen[got.kind] = 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin : drive_and_check
      logic        took;
      logic        rsp_took;
      logic        hit;
      report_type  pred;
      rx_item_type cur;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
         ps_phase = PH_IDLE;
         ps_left = '0;
         ps_count = '0;
         ps_sum = '0;
         foreach (ps_store[i]) ps_store[i] = '0;
      end else begin
         took = req_valid && req_ready;
         rsp_took = rsp_valid && rsp_ready;

         if (rsp_took)
            check_report(report_type'{kind_type'(rsp_frame_kind), rsp_quality, rsp_light,
                                      rsp_word_a, rsp_word_b, rsp_word_c, rsp_word_d,
                                      rsp_word_e, rsp_word_f});

         if (took) begin
            cur = rx_stream[feed_idx];
            feed_idx++;
            parse_byte(cur.b, hit, pred);
            if (cur.src == GIVEN_REPORT) pending_reports.push_back(cur.rpt);
            else if (cur.src == FROM_PARSER && hit) pending_reports.push_back(pred);
         end

         // sender: bursts of items separated by random gaps
         if (!req_valid || took) begin
            if (feed_idx >= rx_stream.size()) begin
               req_valid <= 1'b0;
            end else if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_rx_byte <= rx_stream[feed_idx].b;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end
         end

         // receiver: repeating stall pattern, swapped for a new one whenever pat_age wraps
         if (pat_age == 63) begin
            pat_age = 0;
            ready_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
         end else begin
            pat_age++;
         end
         pat_pos = (pat_pos + 1) % 16;
         rsp_ready <= ready_pat[pat_pos];

         if (took || rsp_took) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles, %0d reports still due",
                     quiet_cycles, pending_reports.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      frame_row_type row;
      int pick;

      // directed frames: all eight kinds, extremes, dropped and refused frames
      dir_tab[0] = frame_row_type'{4'd0, 64'h0, FUNC_HEIGHT, 8'd3, MODE_RAW,
         {16'hFFFF, 112'h0}, 1'b0, 8'h00, GIVEN_REPORT,
         report_type'{KIND_HGT_RAW, 8'h00, 8'h00, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0,
                      16'h0}};
      dir_tab[1] = frame_row_type'{4'd0, 64'h0, FUNC_HEIGHT, 8'd3, MODE_FUSED,
         128'h0, 1'b0, 8'h00, GIVEN_REPORT,
         report_type'{KIND_HGT_FUSED, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                      16'h0}};
      // dx / dy at the signed extremes
      dir_tab[2] = frame_row_type'{4'd0, 64'h0, FUNC_FLOW, 8'd5, MODE_RAW,
         {32'hC8807FFF, 96'h0}, 1'b0, 8'h00, GIVEN_REPORT,
         report_type'{KIND_FLOW_RAW, 8'hC8, 8'hFF, 16'hFF80, 16'h007F, 16'h0, 16'h0, 16'h0,
                      16'h0}};
      dir_tab[3] = frame_row_type'{4'd0, 64'h0, FUNC_FLOW, 8'd11, MODE_FUSED,
         128'h0, 1'b1, 8'h00, FROM_PARSER, NO_REPORT_VAL};
      dir_tab[4] = frame_row_type'{4'd0, 64'h0, FUNC_IMU, 8'd13, MODE_RAW,
         128'h0, 1'b1, 8'h00, FROM_PARSER, NO_REPORT_VAL};
      dir_tab[5] = frame_row_type'{4'd0, 64'h0, FUNC_IMU, 8'd13, MODE_FUSED,
         {{12{8'hFF}}, 32'h0}, 1'b0, 8'h00, GIVEN_REPORT,
         report_type'{KIND_IMU_FILT, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                      16'hFFFF, 16'hFFFF, 16'hFFFF}};
      dir_tab[6] = frame_row_type'{4'd0, 64'h0, FUNC_ATT, 8'd7, MODE_RAW,
         128'h0, 1'b1, 8'h00, FROM_PARSER, NO_REPORT_VAL};
      dir_tab[7] = frame_row_type'{4'd0, 64'h0, FUNC_ATT, 8'd9, MODE_FUSED,
         128'h0, 1'b1, 8'h00, FROM_PARSER, NO_REPORT_VAL};
      // zero length: the byte after the length drops the frame
      dir_tab[8] = frame_row_type'{4'd0, 64'h0, FUNC_HEIGHT, 8'd0, MODE_RAW,
         128'h0, 1'b0, 8'h00, NO_REPORT, NO_REPORT_VAL};
      // bad checksum
      dir_tab[9] = frame_row_type'{4'd0, 64'h0, FUNC_HEIGHT, 8'd3, MODE_RAW,
         {16'h1234, 112'h0}, 1'b0, 8'h01, NO_REPORT, NO_REPORT_VAL};
      dir_tab[10] = frame_row_type'{4'd0, 64'h0, FUNC_UNKNOWN, 8'd3, MODE_RAW,
         128'h0, 1'b0, 8'h00, NO_REPORT, NO_REPORT_VAL};
      // highest accepted function with the longest payload
      dir_tab[11] = frame_row_type'{4'd0, 64'h0, FUNC_LIMIT - 8'd1, 8'(MAX_PAYLOAD),
         MODE_FUSED, 128'h0, 1'b1, 8'h00, NO_REPORT, NO_REPORT_VAL};
      dir_tab[12] = frame_row_type'{4'd0, 64'h0, FUNC_IMU, 8'd13, MODE_BAD,
         128'h0, 1'b0, 8'h00, NO_REPORT, NO_REPORT_VAL};
      dir_tab[13] = frame_row_type'{4'd0, 64'h0, FUNC_LIMIT, 8'd3, MODE_RAW,
         128'h0, 1'b0, 8'h00, NO_REPORT, NO_REPORT_VAL};
      dir_tab[14] = frame_row_type'{4'd0, 64'h0, FUNC_HEIGHT, 8'(MAX_PAYLOAD + 1), MODE_RAW,
         128'h0, 1'b0, 8'h00, NO_REPORT, NO_REPORT_VAL};
      dir_tab[15] = frame_row_type'{4'd0, 64'h0, FUNC_IMU, 8'(MAX_PAYLOAD), MODE_RAW,
         128'h0, 1'b1, 8'h00, FROM_PARSER, NO_REPORT_VAL};
      // AA as a length is refused and not taken as a new header
      dir_tab[16] = frame_row_type'{4'd4, 64'hAAAA51AA_00000000, FUNC_HEIGHT, 8'd3,
         MODE_FUSED, 128'h0, 1'b1, 8'h00, FROM_PARSER, NO_REPORT_VAL};
      dir_tab[17] = frame_row_type'{4'd5, 64'hAA00AAAAF5_000000, FUNC_ATT, 8'd7, MODE_RAW,
         128'h0, 1'b1, 8'h00, FROM_PARSER, NO_REPORT_VAL};
      // short frames decode stale store bytes and their own checksum; the last frame runs past the store's end
      dir_tab[18] = frame_row_type'{4'd0, 64'h0, FUNC_IMU, 8'd1, MODE_FUSED,
         128'h0, 1'b1, 8'h00, FROM_PARSER, NO_REPORT_VAL};
      dir_tab[19] = frame_row_type'{4'd0, 64'h0, FUNC_FLOW, 8'd1, MODE_RAW,
         128'h0, 1'b1, 8'h00, FROM_PARSER, NO_REPORT_VAL};
      dir_tab[20] = frame_row_type'{4'd0, 64'h0, FUNC_FLOW, 8'd17, MODE_FUSED,
         128'h0, 1'b1, 8'h00, FROM_PARSER, NO_REPORT_VAL};

      foreach (dir_tab[i]) queue_frame(dir_tab[i]);

      // random frames: mostly well formed, some junk, bad sums and odd codes
      while (rx_stream.size() < STREAM_TARGET) begin
         row = '0;
         row.rnd = 1'b1;
         row.src = FROM_PARSER;
         if ($urandom_range(0, 99) < 85) begin
            case ($urandom_range(0, 3))
               0: row.func = FUNC_FLOW;
               1: row.func = FUNC_HEIGHT;
               2: row.func = FUNC_IMU;
               default: row.func = FUNC_ATT;
            endcase
         end else begin
            row.func = 8'($urandom_range(0, 255));
         end
         row.mode = ($urandom_range(0, 99) < 88) ? 8'($urandom_range(0, 1))
                                                 : 8'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            case (row.func)
               FUNC_FLOW:   row.len = row.mode[0] ? 8'd11 : 8'd5;
               FUNC_HEIGHT: row.len = 8'd3;
               FUNC_ATT:    row.len = row.mode[0] ? 8'd9 : 8'd7;
               default:     row.len = 8'd13;
            endcase
         end else if (pick < 90) begin
            row.len = 8'($urandom_range(0, 17));
         end else if (pick < 97) begin
            row.len = 8'($urandom_range(18, MAX_PAYLOAD));
         end else begin
            row.len = 8'($urandom_range(MAX_PAYLOAD + 1, 63));
         end
         if ($urandom_range(0, 9) == 0) row.cks_adj = 8'($urandom_range(1, 255));
         if ($urandom_range(0, 6) == 0) begin
            row.npre = 4'($urandom_range(1, 8));
            for (int k = 0; k < row.npre; k++)
               row.pre[63 - 8 * k -: 8] = ($urandom_range(0, 4) < 2) ? HDR_BYTE
                                                                    : 8'($urandom_range(0, 255));
         end
         queue_frame(row);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (feed_idx < rx_stream.size() || pending_reports.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("fed %0d bytes in %0d frames, %0d reports checked, kinds seen %08b",
               feed_idx, frames_built, reports_checked, kinds_seen);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/offp_pkg.sv
hw/rtl/optical_flow_frame_parser_top.sv
tb/sv/optical_flow_frame_parser_top_tb.sv
